@@ rtl/core/skeleton_forward_kinematics_core_defines.svh @@
// Assertion macros shared by the forward kinematics core.
// No dependencies.
`ifndef SKELETON_FORWARD_KINEMATICS_CORE_DEFINES_SVH
`define SKELETON_FORWARD_KINEMATICS_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SFK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SFK_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/core/sfk_pkg.sv @@
// Types, constants and arithmetic helpers for the forward kinematics core.
// No dependencies.
package sfk_pkg;
  localparam int unsigned JointsDefault = 128;

  typedef struct packed {
    logic [6:0]         joint_index;
    logic [6:0]         parent_index;
    logic               is_root;
    logic [47:0]        rot_row_a;
    logic [47:0]        rot_row_b;
    logic [47:0]        rot_row_c;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
  } sfk_in_t;

  typedef struct packed {
    logic [6:0]         out_joint;
    logic [47:0]        glob_row_a;
    logic [47:0]        glob_row_b;
    logic [47:0]        glob_row_c;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] rel_root_x;
    logic signed [31:0] rel_root_y;
    logic signed [31:0] rel_root_z;
  } sfk_out_t;

  // Stored transform of one joint.
  typedef struct packed {
    logic [47:0] row_a;
    logic [47:0] row_b;
    logic [47:0] row_c;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } sfk_xform_t;

  function automatic logic [15:0] sat16(input logic signed [35:0] v);
    logic signed [35:0] s;
    s = v >>> 14;
    if (s > 36'sd32767) return 16'h7fff;
    else if (s < -36'sd32768) return 16'h8000;
    else return s[15:0];
  endfunction

  // The shifted position sum plus the parent position needs 35 bits.
  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'h7fffffff;
    else if (v < -36'sd2147483648) return 32'h80000000;
    else return v[31:0];
  endfunction
endpackage

@@ rtl/core/sfk_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sfk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/skeleton_forward_kinematics_core.sv @@
// Forward kinematics core: top level.
// Uses sfk_pkg, sfk_ram and the assertion macro header.
//
// Usage: one joint word enters on in_valid/in_ready, parents before
// children. The transform memory is read at the parent index in the
// accept cycle; stage 2 registers the products of the 3x3 parent rotation
// with the local rotation and offset (one 16x16 or 16x32 multiplier per
// term), and stage 3 sums, shifts, saturates, writes the joint's transform
// back and loads the output register. A child may directly follow its
// parent: the freshly written transform is forwarded around the registered
// memory read. Throughput: one word per cycle while the receiver keeps
// taking words, set by the read-multiply-writeback pipeline with forwarding.
// Reset (rst_n, synchronous) empties the pipeline and clears the latched
// root position; memory contents stay undefined until written.
// When the receiver stalls, the output register holds its word and earlier
// stages only fill bubbles; in_ready drops only once all stages are full.
`include "skeleton_forward_kinematics_core_defines.svh"
module skeleton_forward_kinematics_core #(
  parameter int unsigned JOINTS = sfk_pkg::JointsDefault
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sfk_pkg::sfk_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sfk_pkg::sfk_out_t out_data
);
  import sfk_pkg::*;

  localparam int unsigned AddrW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int unsigned XW = $bits(sfk_xform_t);

  // Stage 1 (memory read) and stage 2 (products) registers.
  logic       s1_v_r, s1_v_nxt;
  sfk_in_t    s1_d_r;
  logic       s1_pok_r;
  logic       s2_v_r, s2_v_nxt;
  sfk_in_t    s2_d_r;
  logic signed [31:0] pm_r [3][3][3]; // Gp(i,k)*L(k,j) products, Q4.28
  logic signed [47:0] po_r [3][3];   // Gp(i,k)*off_k
  logic signed [31:0] pp_r [3];
  logic       o_v_r;
  sfk_out_t   o_d_r;
  logic signed [31:0] root_r [3];

  logic adv_o, adv2, adv1;
  assign adv_o = !o_v_r || out_ready;
  assign adv2  = !s2_v_r || adv_o;
  assign adv1  = !s1_v_r || adv2;
  assign in_ready = adv1;

  // Transform memory.
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  sfk_xform_t       wdata, rdata;
  logic [AddrW-1:0] s1_addr_r;

  sfk_ram #(.Width(XW), .Depth(JOINTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // The read address is held while stage 1 stalls so data stays valid.
  assign raddr = (in_valid && in_ready) ? AddrW'(in_data.parent_index) : s1_addr_r;

  // Write-back history for forwarding: writes issued after the read.
  logic             fw_v_r;
  logic [AddrW-1:0] fw_a_r;
  sfk_xform_t       fw_d_r;
  logic             fw1_v_r;
  logic [AddrW-1:0] fw1_a_r;
  sfk_xform_t       fw1_d_r;

  // Parent transform seen in stage 1, with forwarding of stores that
  // landed after or during the memory read.
  sfk_xform_t par;
  always_comb begin
    par = rdata;
    if (fw1_v_r && fw1_a_r == s1_addr_r) par = fw1_d_r;
    if (fw_v_r && fw_a_r == s1_addr_r) par = fw_d_r;
    if (we && waddr == s1_addr_r) par = wdata;
    if (!s1_pok_r) par = '0;
  end

  // Stage 1 keeps its parent transform in a register while stalled, since
  // the forwarding registers hold only the previous cycle's write. A parent
  // written in the cycle the stall ends is still taken from the write port.
  sfk_xform_t par_hold_r;
  logic       hold_v_r;
  sfk_xform_t par_use;
  always_comb begin
    par_use = hold_v_r ? par_hold_r : par;
    if (we && waddr == s1_addr_r && s1_pok_r) par_use = wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (s1_v_r && !adv2) begin
      hold_v_r <= 1'b1;
    end else begin
      hold_v_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (s1_v_r && !adv2) begin
      par_hold_r <= par_use;
    end
  end

  logic signed [15:0] gp [3][3];
  logic signed [15:0] lr [3][3];
  logic signed [31:0] off [3];
  always_comb begin
    gp[0][0] = par_use.row_a[15:0];  gp[0][1] = par_use.row_a[31:16];
    gp[0][2] = par_use.row_a[47:32];
    gp[1][0] = par_use.row_b[15:0];  gp[1][1] = par_use.row_b[31:16];
    gp[1][2] = par_use.row_b[47:32];
    gp[2][0] = par_use.row_c[15:0];  gp[2][1] = par_use.row_c[31:16];
    gp[2][2] = par_use.row_c[47:32];
    lr[0][0] = s1_d_r.rot_row_a[15:0];  lr[0][1] = s1_d_r.rot_row_a[31:16];
    lr[0][2] = s1_d_r.rot_row_a[47:32];
    lr[1][0] = s1_d_r.rot_row_b[15:0];  lr[1][1] = s1_d_r.rot_row_b[31:16];
    lr[1][2] = s1_d_r.rot_row_b[47:32];
    lr[2][0] = s1_d_r.rot_row_c[15:0];  lr[2][1] = s1_d_r.rot_row_c[31:16];
    lr[2][2] = s1_d_r.rot_row_c[47:32];
    off[0] = s1_d_r.offset_x;
    off[1] = s1_d_r.offset_y;
    off[2] = s1_d_r.offset_z;
  end

  assign s1_v_nxt = (in_valid && in_ready) ? 1'b1 : (adv2 ? 1'b0 : s1_v_r);
  assign s2_v_nxt = adv2 ? s1_v_r : s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_d_r    <= in_data;
      s1_addr_r <= AddrW'(in_data.parent_index);
      s1_pok_r  <= 32'(in_data.parent_index) < JOINTS;
    end
    if (adv2 && s1_v_r) begin
      s2_d_r <= s1_d_r;
      for (int i = 0; i < 3; i++) begin
        pp_r[i] <= (i == 0) ? par_use.px : ((i == 1) ? par_use.py : par_use.pz);
        for (int k = 0; k < 3; k++) begin
          po_r[i][k] <= 48'(gp[i][k]) * 48'(off[k]);
        end
        for (int j = 0; j < 3; j++) begin
          pm_r[i][j][0] <= gp[i][0] * lr[0][j];
          pm_r[i][j][1] <= gp[i][1] * lr[1][j];
          pm_r[i][j][2] <= gp[i][2] * lr[2][j];
        end
      end
    end
  end

  // Stage 3: sums, shift, saturation, write-back.
  logic [47:0]        grow [3];
  logic [31:0]        pos [3];
  logic signed [35:0] gacc;
  logic signed [49:0] pacc;
  logic signed [35:0] pshift;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        gacc = 36'(pm_r[i][j][0]) + 36'(pm_r[i][j][1]) + 36'(pm_r[i][j][2]);
        grow[i][16*j +: 16] = sat16(gacc);
      end
      pacc = 50'(po_r[i][0]) + 50'(po_r[i][1]) + 50'(po_r[i][2]);
      pshift = 36'(pacc >>> 14);
      pos[i] = sat32(pshift + 36'(pp_r[i]));
    end
    if (s2_d_r.is_root) begin
      grow[0] = s2_d_r.rot_row_a;
      grow[1] = s2_d_r.rot_row_b;
      grow[2] = s2_d_r.rot_row_c;
      pos[0] = s2_d_r.offset_x;
      pos[1] = s2_d_r.offset_y;
      pos[2] = s2_d_r.offset_z;
    end
  end

  logic take2;
  assign take2 = s2_v_r && adv_o;
  assign we    = take2 && (32'(s2_d_r.joint_index) < JOINTS);
  assign waddr = AddrW'(s2_d_r.joint_index);
  assign wdata = '{row_a: grow[0], row_b: grow[1], row_c: grow[2],
                   px: pos[0], py: pos[1], pz: pos[2]};

  // fw_*: previous cycle's write; fw1_*: fw_* delayed again, its valid held low.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_v_r  <= 1'b0;
      fw1_v_r <= 1'b0;
    end else begin
      fw_v_r  <= we;
      fw1_v_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    fw_a_r  <= waddr;
    fw_d_r  <= wdata;
    fw1_a_r <= fw_a_r;
    fw1_d_r <= fw_d_r;
  end

  logic signed [31:0] root_use [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      root_use[i] = s2_d_r.is_root ? pos[i] : root_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
      for (int i = 0; i < 3; i++) root_r[i] <= '0;
    end else begin
      if (adv_o) o_v_r <= s2_v_r;
      if (take2 && s2_d_r.is_root) begin
        for (int i = 0; i < 3; i++) root_r[i] <= pos[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take2) begin
      o_d_r.out_joint  <= s2_d_r.joint_index;
      o_d_r.glob_row_a <= grow[0];
      o_d_r.glob_row_b <= grow[1];
      o_d_r.glob_row_c <= grow[2];
      o_d_r.pos_x      <= pos[0];
      o_d_r.pos_y      <= pos[1];
      o_d_r.pos_z      <= pos[2];
      o_d_r.rel_root_x <= sat32(36'(signed'(pos[0])) - 36'(root_use[0]));
      o_d_r.rel_root_y <= sat32(36'(signed'(pos[1])) - 36'(root_use[1]));
      o_d_r.rel_root_z <= sat32(36'(signed'(pos[2])) - 36'(root_use[2]));
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = o_d_r;

  `SFK_ASSERT_IMP(a_stall_hold, clk, rst_n, out_valid && !out_ready && s2_v_r,
                  !in_ready || !s1_v_r, "pipeline accepted past a full stall")
  `SFK_ASSERT_NXT(a_out_fill, clk, rst_n, take2, out_valid, "stage 3 result not registered")
  `SFK_ASSERT_IMP(a_we_take, clk, rst_n, we, s2_v_r && adv_o, "memory write without a result")
endmodule
